// ===== rtl/core/escu_pkg.sv =====
// shared types, constants and arithmetic helpers for the compensation unit
package escu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned ApbW   = 64;
  localparam int unsigned InW    = 64;
  localparam int unsigned OutW   = 72;
  localparam int unsigned NumRegs = 7;

  localparam logic [23:0] TempOff  = 24'h800000;
  localparam logic [23:0] PressOff = 24'h800000;
  localparam logic [15:0] HumOff   = 16'h8000;
  localparam logic [15:0] OffsetReset = 16'd2000;

  // register indexes
  typedef enum logic [2:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL_A   = 3'd4,
    REG_HUM_CAL_B   = 3'd5,
    REG_PRESS_TOFF  = 3'd6,
    REG_NONE        = 3'd7
  } reg_idx_e;

  // raw register contents as seen by the datapath
  typedef struct packed {
    logic [47:0] temp_cal;
    logic [63:0] press_cal_a;
    logic [63:0] press_cal_b;
    logic [15:0] press_cal_c;
    logic [39:0] hum_cal_a;
    logic [31:0] hum_cal_b;
    logic [15:0] press_toff;
  } cal_t;

  // sequencer steps
  typedef enum logic [5:0] {
    S_IDLE,
    S_T0, S_T1, S_T2, S_T3,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_P9, S_P10, S_P11, S_P12, S_P13, S_P14, S_P15, S_P16,
    S_H0, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8, S_H9,
    S_OUT
  } step_e;

  // floor shift
  function automatic logic signed [31:0] asr(input logic signed [31:0] a,
                                             input int unsigned n);
    return a >>> n;
  endfunction

  // shift toward zero
  function automatic logic signed [31:0] tsr(input logic signed [31:0] a,
                                             input int unsigned n);
    logic [31:0] mag;
    mag = 32'd0 - a;
    if (a[31]) begin
      return 32'd0 - (mag >> n);
    end
    return a >>> n;
  endfunction

endpackage

// ===== rtl/core/escu_cfg.sv =====
// calibration register file behind the apb port
module escu_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::AddrW-1:0]    paddr,
  input  logic [escu_pkg::ApbW-1:0]     pwdata,
  output logic [escu_pkg::ApbW-1:0]     prdata,
  output logic                          pready,
  output escu_pkg::cal_t                cal_o
);

  escu_pkg::cal_t   cal_q;
  escu_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx   = escu_pkg::reg_idx_e'(paddr[5:3]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cal_o = cal_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q.temp_cal    <= '0;
      cal_q.press_cal_a <= '0;
      cal_q.press_cal_b <= '0;
      cal_q.press_cal_c <= '0;
      cal_q.hum_cal_a   <= '0;
      cal_q.hum_cal_b   <= '0;
      cal_q.press_toff  <= escu_pkg::OffsetReset;
    end else if (wr_en) begin
      unique case (idx)
        escu_pkg::REG_TEMP_CAL:    cal_q.temp_cal    <= pwdata[47:0];
        escu_pkg::REG_PRESS_CAL_A: cal_q.press_cal_a <= pwdata;
        escu_pkg::REG_PRESS_CAL_B: cal_q.press_cal_b <= pwdata;
        escu_pkg::REG_PRESS_CAL_C: cal_q.press_cal_c <= pwdata[15:0];
        escu_pkg::REG_HUM_CAL_A:   cal_q.hum_cal_a   <= pwdata[39:0];
        escu_pkg::REG_HUM_CAL_B:   cal_q.hum_cal_b   <= pwdata[31:0];
        escu_pkg::REG_PRESS_TOFF:  cal_q.press_toff  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      escu_pkg::REG_TEMP_CAL:    prdata = {16'd0, cal_q.temp_cal};
      escu_pkg::REG_PRESS_CAL_A: prdata = cal_q.press_cal_a;
      escu_pkg::REG_PRESS_CAL_B: prdata = cal_q.press_cal_b;
      escu_pkg::REG_PRESS_CAL_C: prdata = {48'd0, cal_q.press_cal_c};
      escu_pkg::REG_HUM_CAL_A:   prdata = {24'd0, cal_q.hum_cal_a};
      escu_pkg::REG_HUM_CAL_B:   prdata = {32'd0, cal_q.hum_cal_b};
      escu_pkg::REG_PRESS_TOFF:  prdata = {48'd0, cal_q.press_toff};
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/escu_div.sv =====
// radix-2 restoring unsigned divider, one quotient bit per cycle
module escu_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [escu_pkg::DataW-1:0]   dividend_i,
  input  logic [escu_pkg::DataW-1:0]   divisor_i,
  output logic                         done_o,
  output logic [escu_pkg::DataW-1:0]   quot_o
);

  localparam int unsigned W  = escu_pkg::DataW;
  localparam int unsigned CW = $clog2(W + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d, done_q, done_d;
  logic [W:0]    rem_q, rem_d, rem_sh;
  logic [W-1:0]  quo_q, quo_d, dvs_q, dvs_d;

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};

  // one compare and subtract per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CW'(W);
      busy_d = 1'b1;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sh - {1'b0, dvs_q};
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== rtl/core/environment_sensor_compensation_unit.sv =====
// top level: sequencer around one shared multiplier, divider and register file
//
// Compensates one raw temperature, pressure and humidity reading per item
// with the 32-bit integer formulas. When pressure is skipped (channel off
// or zero divisor) the sequencer runs 26 steps around the single registered
// 32x32 multiplier, the last one loading the result into the output
// register; a pressure division adds a wait on the bit-serial divider in
// step P11 and the final pressure terms in steps P12 to P16. The input is
// not ready while an item is in work; the finished result sits in an output
// register and the next item can be taken the cycle after it is loaded.
// Calibration is written through the APB port at byte address 8*index; the
// user must write it only while the unit is idle, as the block does not
// enforce this.
module environment_sensor_compensation_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // raw_temp [23:0], raw_press [47:24], raw_hum [63:48]
  input  logic [escu_pkg::InW-1:0]      s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // temp_centi [15:0], temp_valid [16], press_pa [48:17], press_valid [49],
  // hum_q10 [66:50], hum_valid [67], zero fill [71:68]
  output logic [escu_pkg::OutW-1:0]     m_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escu_pkg::AddrW-1:0]    paddr,
  input  logic [escu_pkg::ApbW-1:0]     pwdata,
  output logic [escu_pkg::ApbW-1:0]     prdata,
  output logic                          pready
);

  escu_pkg::cal_t  cal;
  escu_pkg::step_e st_q, st_d;

  logic [23:0] rt_q, rp_q;
  logic [15:0] rh_q;
  logic        ten, pen, hen;

  logic signed [31:0] r0_q, r0_d, r1_q, r1_d, r2_q, r2_d, r3_q, r3_d;
  logic signed [31:0] pr_q, mul_a, mul_b, mul_p;
  logic signed [31:0] ft_q, ft_d, ftw_q, ftw_d;
  logic signed [15:0] tc_q, tc_d;
  logic [31:0]        press_q, press_d;
  logic [16:0]        hum_q, hum_d;
  logic               pv_q, pv_d, dbl_q, dbl_d;
  logic               mv_q, mv_d;
  logic [escu_pkg::OutW-1:0] mdata_q, mdata_d;

  logic               div_start, div_done;
  logic [31:0]        div_dvd, div_q;

  // trims widened to 32-bit signed
  logic signed [31:0] t1w, t2w, t3w;
  logic signed [31:0] p1w, p2w, p3w, p4w, p5w, p6w, p7w, p8w, p9w, offw;
  logic signed [31:0] h1w, h2w, h3w, h4w, h5w, h6w;
  logic signed [31:0] adct, adcp, adch;

  // scratch for the longer steps
  logic signed [35:0] tnum, tsh;
  logic signed [31:0] tmp, hv;

  escu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal_o   (cal)
  );

  escu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (r0_q),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  assign t1w  = {16'd0, cal.temp_cal[15:0]};
  assign t2w  = {{16{cal.temp_cal[31]}}, cal.temp_cal[31:16]};
  assign t3w  = {{16{cal.temp_cal[47]}}, cal.temp_cal[47:32]};
  assign p1w  = {16'd0, cal.press_cal_a[15:0]};
  assign p2w  = {{16{cal.press_cal_a[31]}}, cal.press_cal_a[31:16]};
  assign p3w  = {{16{cal.press_cal_a[47]}}, cal.press_cal_a[47:32]};
  assign p4w  = {{16{cal.press_cal_a[63]}}, cal.press_cal_a[63:48]};
  assign p5w  = {{16{cal.press_cal_b[15]}}, cal.press_cal_b[15:0]};
  assign p6w  = {{16{cal.press_cal_b[31]}}, cal.press_cal_b[31:16]};
  assign p7w  = {{16{cal.press_cal_b[47]}}, cal.press_cal_b[47:32]};
  assign p8w  = {{16{cal.press_cal_b[63]}}, cal.press_cal_b[63:48]};
  assign p9w  = {{16{cal.press_cal_c[15]}}, cal.press_cal_c};
  assign offw = {{16{cal.press_toff[15]}}, cal.press_toff};
  assign h1w  = {24'd0, cal.hum_cal_a[7:0]};
  assign h2w  = {{16{cal.hum_cal_a[23]}}, cal.hum_cal_a[23:8]};
  assign h3w  = {24'd0, cal.hum_cal_a[31:24]};
  assign h6w  = {{24{cal.hum_cal_a[39]}}, cal.hum_cal_a[39:32]};
  assign h4w  = {16'd0, cal.hum_cal_b[15:0]};
  assign h5w  = {{16{cal.hum_cal_b[31]}}, cal.hum_cal_b[31:16]};

  assign adct = {12'd0, rt_q[23:4]};
  assign adcp = {12'd0, rp_q[23:4]};
  assign adch = {16'd0, rh_q};
  assign ten  = (rt_q != escu_pkg::TempOff);
  assign pen  = (rp_q != escu_pkg::PressOff);
  assign hen  = (rh_q != escu_pkg::HumOff);

  // the shared multiplier, low 32 bits, registered
  assign mul_p = 32'(mul_a * mul_b);

  assign s_axis_tready = (st_q == escu_pkg::S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

  // sequencer: at most one multiply and a little add/shift work per step
  always_comb begin
    st_d      = st_q;
    r0_d      = r0_q;
    r1_d      = r1_q;
    r2_d      = r2_q;
    r3_d      = r3_q;
    ft_d      = ft_q;
    ftw_d     = ftw_q;
    tc_d      = tc_q;
    press_d   = press_q;
    hum_d     = hum_q;
    pv_d      = pv_q;
    dbl_d     = dbl_q;
    mv_d      = mv_q;
    mdata_d   = mdata_q;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = pr_q;
    tnum      = '0;
    tsh       = '0;
    tmp       = '0;
    hv        = '0;

    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end

    unique case (st_q)
      escu_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          st_d = escu_pkg::S_T0;
        end
      end
      // temperature
      escu_pkg::S_T0: begin
        mul_a = escu_pkg::asr(adct, 3) - (t1w <<< 1);
        mul_b = t2w;
        r0_d  = escu_pkg::asr(adct, 4) - t1w;
        st_d  = escu_pkg::S_T1;
      end
      escu_pkg::S_T1: begin
        mul_a = r0_q;
        mul_b = r0_q;
        r1_d  = escu_pkg::asr(pr_q, 11);
        st_d  = escu_pkg::S_T2;
      end
      escu_pkg::S_T2: begin
        mul_a = escu_pkg::asr(pr_q, 12);
        mul_b = t3w;
        st_d  = escu_pkg::S_T3;
      end
      escu_pkg::S_T3: begin
        tmp   = r1_q + escu_pkg::asr(pr_q, 14);
        ftw_d = ten ? tmp : ft_q;
        ft_d  = ten ? tmp : ft_q;
        st_d  = escu_pkg::S_P0;
      end
      // saturated centidegrees and first pressure term
      escu_pkg::S_P0: begin
        tnum = 36'(ftw_q) * 36'sd5 + 36'sd128;
        tsh  = tnum >>> 8;
        if (tsh > 36'sd32767) begin
          tc_d = 16'sh7fff;
        end else if (tsh < -36'sd32768) begin
          tc_d = 16'sh8000;
        end else begin
          tc_d = tsh[15:0];
        end
        r0_d = escu_pkg::asr(ftw_q + offw, 1) - 32'sd64000;
        st_d = escu_pkg::S_P1;
      end
      escu_pkg::S_P1: begin
        mul_a = escu_pkg::asr(r0_q, 2);
        mul_b = escu_pkg::asr(r0_q, 2);
        st_d  = escu_pkg::S_P2;
      end
      escu_pkg::S_P2: begin
        mul_a = escu_pkg::asr(pr_q, 11);
        mul_b = p6w;
        st_d  = escu_pkg::S_P3;
      end
      escu_pkg::S_P3: begin
        r2_d  = pr_q;
        mul_a = r0_q;
        mul_b = p5w;
        st_d  = escu_pkg::S_P4;
      end
      escu_pkg::S_P4: begin
        r2_d  = r2_q + (pr_q <<< 1);
        mul_a = p2w;
        mul_b = r0_q;
        st_d  = escu_pkg::S_P5;
      end
      escu_pkg::S_P5: begin
        r2_d  = escu_pkg::tsr(r2_q, 2) + (p4w <<< 16);
        r3_d  = escu_pkg::tsr(pr_q, 1);
        mul_a = escu_pkg::tsr(r0_q, 2);
        mul_b = escu_pkg::tsr(r0_q, 2);
        st_d  = escu_pkg::S_P6;
      end
      escu_pkg::S_P6: begin
        mul_a = p3w;
        mul_b = escu_pkg::asr(pr_q, 13);
        st_d  = escu_pkg::S_P7;
      end
      escu_pkg::S_P7: begin
        r0_d = escu_pkg::tsr(escu_pkg::asr(pr_q, 3) + r3_q, 18);
        st_d = escu_pkg::S_P8;
      end
      escu_pkg::S_P8: begin
        mul_a = r0_q + 32'sd32768;
        mul_b = p1w;
        st_d  = escu_pkg::S_P9;
      end
      escu_pkg::S_P9: begin
        r0_d  = escu_pkg::tsr(pr_q, 15);
        mul_a = (32'sd1048576 - adcp) - escu_pkg::tsr(r2_q, 12);
        mul_b = 32'sd3125;
        st_d  = escu_pkg::S_P10;
      end
      // divide, or skip pressure on zero divisor or channel off
      escu_pkg::S_P10: begin
        if (!pen || r0_q == '0) begin
          pv_d    = 1'b0;
          press_d = '0;
          st_d    = escu_pkg::S_H0;
        end else begin
          div_start = 1'b1;
          div_dvd   = pr_q[31] ? pr_q : (pr_q <<< 1);
          dbl_d     = pr_q[31];
          st_d      = escu_pkg::S_P11;
        end
      end
      escu_pkg::S_P11: begin
        if (div_done) begin
          r1_d = dbl_q ? (div_q << 1) : div_q;
          st_d = escu_pkg::S_P12;
        end
      end
      escu_pkg::S_P12: begin
        mul_a = {3'd0, r1_q[31:3]};
        mul_b = {3'd0, r1_q[31:3]};
        st_d  = escu_pkg::S_P13;
      end
      escu_pkg::S_P13: begin
        mul_a = p9w;
        mul_b = {13'd0, pr_q[31:13]};
        st_d  = escu_pkg::S_P14;
      end
      escu_pkg::S_P14: begin
        r2_d  = escu_pkg::asr(pr_q, 12);
        mul_a = {2'd0, r1_q[31:2]};
        mul_b = p8w;
        st_d  = escu_pkg::S_P15;
      end
      escu_pkg::S_P15: begin
        r2_d = r2_q + escu_pkg::tsr(pr_q, 13) + p7w;
        st_d = escu_pkg::S_P16;
      end
      escu_pkg::S_P16: begin
        press_d = r1_q + escu_pkg::asr(r2_q, 4);
        pv_d    = 1'b1;
        st_d    = escu_pkg::S_H0;
      end
      // humidity
      escu_pkg::S_H0: begin
        r0_d = ftw_q - 32'sd76800;
        st_d = escu_pkg::S_H1;
      end
      escu_pkg::S_H1: begin
        mul_a = h5w;
        mul_b = r0_q;
        st_d  = escu_pkg::S_H2;
      end
      escu_pkg::S_H2: begin
        r1_d  = escu_pkg::asr((adch <<< 14) - (h4w <<< 20) - pr_q + 32'sd16384, 15);
        mul_a = r0_q;
        mul_b = h6w;
        st_d  = escu_pkg::S_H3;
      end
      escu_pkg::S_H3: begin
        r2_d  = escu_pkg::asr(pr_q, 10);
        mul_a = r0_q;
        mul_b = h3w;
        st_d  = escu_pkg::S_H4;
      end
      escu_pkg::S_H4: begin
        mul_a = r2_q;
        mul_b = escu_pkg::asr(pr_q, 11) + 32'sd32768;
        st_d  = escu_pkg::S_H5;
      end
      escu_pkg::S_H5: begin
        mul_a = escu_pkg::asr(pr_q, 10) + 32'sd2097152;
        mul_b = h2w;
        st_d  = escu_pkg::S_H6;
      end
      escu_pkg::S_H6: begin
        mul_a = r1_q;
        mul_b = escu_pkg::asr(pr_q + 32'sd8192, 14);
        st_d  = escu_pkg::S_H7;
      end
      escu_pkg::S_H7: begin
        r3_d  = pr_q;
        mul_a = escu_pkg::asr(pr_q, 15);
        mul_b = escu_pkg::asr(pr_q, 15);
        st_d  = escu_pkg::S_H8;
      end
      escu_pkg::S_H8: begin
        mul_a = escu_pkg::asr(pr_q, 7);
        mul_b = h1w;
        st_d  = escu_pkg::S_H9;
      end
      escu_pkg::S_H9: begin
        hv = r3_q - escu_pkg::asr(pr_q, 4);
        if (hv[31]) begin
          hv = '0;
        end else if (hv > 32'sd419430400) begin
          hv = 32'sd419430400;
        end
        hum_d = hv[28:12];
        st_d  = escu_pkg::S_OUT;
      end
      // load the output register once it is free
      escu_pkg::S_OUT: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          mdata_d = {4'd0, hen, hen ? hum_q : 17'd0, pv_q,
                     pv_q ? press_q : 32'd0, ten, ten ? tc_q : 16'sd0};
          st_d    = escu_pkg::S_IDLE;
        end
      end
      default: st_d = escu_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= escu_pkg::S_IDLE;
      mv_q <= 1'b0;
      ft_q <= '0;
    end else begin
      st_q <= st_d;
      mv_q <= mv_d;
      ft_q <= ft_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      rt_q <= s_axis_tdata[23:0];
      rp_q <= s_axis_tdata[47:24];
      rh_q <= s_axis_tdata[63:48];
    end
    pr_q    <= mul_p;
    r0_q    <= r0_d;
    r1_q    <= r1_d;
    r2_q    <= r2_d;
    r3_q    <= r3_d;
    ftw_q   <= ftw_d;
    tc_q    <= tc_d;
    press_q <= press_d;
    hum_q   <= hum_d;
    pv_q    <= pv_d;
    dbl_q   <= dbl_d;
    mdata_q <= mdata_d;
  end

endmodule
